### src/pvca_pkg.sv
`default_nettype none

package pvca_pkg;

   // Input request codes.
   localparam logic [1:0] REQ_START    = 2'd0;
   localparam logic [1:0] REQ_STOP     = 2'd1;
   localparam logic [1:0] REQ_STOP_ALL = 2'd2;
   localparam logic [1:0] REQ_TICK     = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_GRANTED  = 2'd0;
   localparam logic [1:0] ST_REJECTED = 2'd1;
   localparam logic [1:0] ST_DONE     = 2'd2;

   // Register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPAT   = 2'd2;

   localparam logic [4:0] CHANNELS_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] emitter_id;
      logic [7:0]  sound_priority;
      logic        pickup;
      logic [23:0] play_length;
      logic [31:0] now_time;
   } pvca_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  channel_index;
      logic [15:0] freed_mask;
   } pvca_rsp_type;

   typedef struct packed {
      logic [4:0] channels_in_use;
      logic       sound_enabled;
      logic       compat_kill_any;
   } pvca_cfg_type;

   // What the back end has to do with a queued command.
   typedef enum logic [2:0] {
      OP_START,
      OP_STOP,
      OP_STOP_ALL,
      OP_TICK,
      OP_REJECT,
      OP_NOP
   } pvca_op_type;

   typedef struct packed {
      pvca_op_type op;
      logic [7:0]  prio;
      logic        pickup;
   } pvca_cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CLAIM,
      BK_EVICT,
      BK_SCAN,
      BK_CLEAR,
      BK_WRITE,
      BK_REPLY
   } pvca_state_type;

endpackage

`default_nettype wire

### src/pvca_ram.sv
`default_nettype none

module pvca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

### src/pvca_front.sv
`default_nettype none

module pvca_front #(
   parameter int EMITTER_BITS = 16,
   parameter int TIME_BITS    = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     enable,
   input  wire logic                     start,
   output logic                          busy,
   input  wire pvca_pkg::pvca_req_type   req_data,
   output logic                          q_valid,
   output pvca_pkg::pvca_cmd_type        q_cmd,
   output logic [EMITTER_BITS-1:0]       q_emit,
   output logic [TIME_BITS-1:0]          q_now,
   output logic [TIME_BITS-1:0]          q_end,
   input  wire logic                     q_take
);
   import pvca_pkg::*;

   localparam int DEPTH = 2;

   pvca_op_type            op_class;
   logic                   push;
   logic                   pop;
   logic [TIME_BITS-1:0]   end_time;

   pvca_cmd_type           cmd_ff  [DEPTH];
   logic [EMITTER_BITS-1:0] emit_ff [DEPTH];
   logic [TIME_BITS-1:0]   now_ff  [DEPTH];
   logic [TIME_BITS-1:0]   end_ff  [DEPTH];

   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             cnt_ff, cnt_in;

   // A disabled block still answers every beat, so a request is never dropped here.
   always_comb begin
      op_class = OP_NOP;
      case (req_data.req_type)
         REQ_START:    op_class = enable ? OP_START : OP_REJECT;
         REQ_STOP:     op_class = enable ? OP_STOP : OP_NOP;
         REQ_STOP_ALL: op_class = enable ? OP_STOP_ALL : OP_NOP;
         REQ_TICK:     op_class = enable ? OP_TICK : OP_NOP;
         default:      op_class = OP_NOP;
      endcase
   end

   // The sum is formed in 33 bits and then cut to the time field width, so an end time past the top of the field wraps.
   assign end_time = TIME_BITS'(33'(req_data.now_time) + 33'(req_data.play_length));

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop     = q_take && q_valid;

   assign q_cmd  = cmd_ff[rd_ptr_ff];
   assign q_emit = emit_ff[rd_ptr_ff];
   assign q_now  = now_ff[rd_ptr_ff];
   assign q_end  = end_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff]  <= '{op: op_class, prio: req_data.sound_priority,
                                pickup: req_data.pickup};
         emit_ff[wr_ptr_ff] <= EMITTER_BITS'(req_data.emitter_id);
         now_ff[wr_ptr_ff]  <= TIME_BITS'(req_data.now_time);
         end_ff[wr_ptr_ff]  <= end_time;
      end
   end

endmodule

`default_nettype wire

### src/pvca_back.sv
`default_nettype none

module pvca_back #(
   parameter int NUM_CHANNELS = 16,
   parameter int EMITTER_BITS = 16,
   parameter int TIME_BITS    = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pvca_pkg::pvca_cfg_type   cfg,
   input  wire logic                     q_valid,
   input  wire pvca_pkg::pvca_cmd_type   q_cmd,
   input  wire logic [EMITTER_BITS-1:0]  q_emit,
   input  wire logic [TIME_BITS-1:0]     q_now,
   input  wire logic [TIME_BITS-1:0]     q_end,
   output logic                          q_take,
   output logic                          rsp_valid,
   output pvca_pkg::pvca_rsp_type        rsp_data
);
   import pvca_pkg::*;

   localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
   localparam int WORD_W = EMITTER_BITS + 1 + 8 + TIME_BITS;

   pvca_state_type          state_ff, state_in;
   pvca_cmd_type            cmd_ff;
   logic [EMITTER_BITS-1:0] emit_ff;
   logic [TIME_BITS-1:0]    now_ff;
   logic [TIME_BITS-1:0]    end_ff;
   logic [CNT_W-1:0]        addr_ff, addr_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic [NUM_CHANNELS-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]        pick_ff, pick_in;
   logic                    kill_done_ff, kill_done_in;
   logic                    reuse_done_ff, reuse_done_in;
   logic [1:0]              status_ff, status_in;

   logic [CNT_W-1:0]        n_eff;
   logic [NUM_CHANNELS-1:0] nmask;

   logic                    ram_we;
   logic [WORD_W-1:0]       ram_wdata;
   logic [WORD_W-1:0]       ram_rdata;
   logic [EMITTER_BITS-1:0] e_emit;
   logic                    e_pick;
   logic [7:0]              e_prio;
   logic [TIME_BITS-1:0]    e_end;

   logic ent_valid, emit_eq, kill_now, post_valid, reuse_now, claim_stop;
   logic evict_hit, stop_hit, tick_hit, exhausted;
   logic scan_stop, issue;

   assign n_eff = (int'(cfg.channels_in_use) > NUM_CHANNELS) ?
                  CNT_W'(NUM_CHANNELS) : CNT_W'(cfg.channels_in_use);

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         nmask[i] = (CNT_W'(i) < n_eff);
      end
   end

   assign ram_wdata = {emit_ff, cmd_ff.pickup, cmd_ff.prio, end_ff};

   pvca_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_CHANNELS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (pick_ff),
      .wdata (ram_wdata),
      .raddr (addr_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   assign {e_emit, e_pick, e_prio, e_end} = ram_rdata;

   // Evaluation of the channel whose table word arrived this cycle.
   assign ent_valid  = valid_ff[rd_idx_ff];
   assign emit_eq    = (e_emit == emit_ff);
   assign kill_now   = rd_vld_ff && !kill_done_ff && ent_valid && emit_eq &&
                       (cfg.compat_kill_any || (e_pick == cmd_ff.pickup));
   // The reuse search sees the table as it stands after the kill step.
   assign post_valid = ent_valid && !kill_now;
   assign reuse_now  = rd_vld_ff && !reuse_done_ff &&
                       (!post_valid || ((emit_ff != '0) && emit_eq &&
                                        (e_pick == cmd_ff.pickup)));
   assign claim_stop = (kill_done_ff || kill_now) && (reuse_done_ff || reuse_now);
   assign evict_hit  = rd_vld_ff && ent_valid && (e_prio >= cmd_ff.prio);
   assign stop_hit   = rd_vld_ff && ent_valid && (cmd_ff.op == OP_STOP) && emit_eq;
   assign tick_hit   = rd_vld_ff && ent_valid && (cmd_ff.op == OP_TICK) &&
                       (now_ff >= e_end);
   assign exhausted  = !rd_vld_ff && (addr_ff >= n_eff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_START:    state_in = BK_CLAIM;
                  OP_STOP:     state_in = BK_SCAN;
                  OP_TICK:     state_in = BK_SCAN;
                  OP_STOP_ALL: state_in = BK_CLEAR;
                  default:     state_in = BK_REPLY;
               endcase
            end
         end
         BK_CLAIM: begin
            if (claim_stop || exhausted) begin
               state_in = (reuse_done_ff || reuse_now) ? BK_WRITE : BK_EVICT;
            end
         end
         BK_EVICT: begin
            if (evict_hit) begin
               state_in = BK_WRITE;
            end else if (exhausted) begin
               state_in = BK_REPLY;
            end
         end
         BK_SCAN: begin
            if (stop_hit || exhausted) begin
               state_in = BK_REPLY;
            end
         end
         BK_CLEAR: state_in = BK_REPLY;
         BK_WRITE: state_in = BK_REPLY;
         BK_REPLY: state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Outputs and scan control.
   always_comb begin
      q_take    = 1'b0;
      ram_we    = 1'b0;
      rsp_valid = 1'b0;
      scan_stop = 1'b0;
      issue     = 1'b0;
      case (state_ff)
         BK_IDLE:  q_take = 1'b1;
         BK_CLAIM: begin
            scan_stop = claim_stop;
            issue     = !scan_stop && (addr_ff < n_eff);
         end
         BK_EVICT: begin
            scan_stop = evict_hit;
            issue     = !scan_stop && (addr_ff < n_eff);
         end
         BK_SCAN: begin
            scan_stop = stop_hit;
            issue     = !scan_stop && (addr_ff < n_eff);
         end
         BK_WRITE: ram_we = 1'b1;
         BK_REPLY: rsp_valid = 1'b1;
         default: begin
            q_take = 1'b0;
         end
      endcase
   end

   // Next values of the table flags and the result being built.
   always_comb begin
      valid_in      = valid_ff;
      mask_in       = mask_ff;
      pick_in       = pick_ff;
      kill_done_in  = kill_done_ff;
      reuse_done_in = reuse_done_ff;
      status_in     = status_ff;
      rd_vld_in     = issue;
      if (state_in != state_ff) begin
         addr_in = '0;
      end else if (issue) begin
         addr_in = addr_ff + CNT_W'(1);
      end else begin
         addr_in = addr_ff;
      end
      case (state_ff)
         BK_IDLE: begin
            mask_in       = '0;
            pick_in       = '0;
            kill_done_in  = 1'b0;
            reuse_done_in = 1'b0;
            status_in     = ((q_cmd.op == OP_START) || (q_cmd.op == OP_REJECT)) ?
                            ST_REJECTED : ST_DONE;
         end
         BK_CLAIM: begin
            if (kill_now) begin
               valid_in[rd_idx_ff] = 1'b0;
               mask_in[rd_idx_ff]  = 1'b1;
               kill_done_in        = 1'b1;
            end
            if (reuse_now) begin
               reuse_done_in = 1'b1;
               pick_in       = rd_idx_ff;
               if (post_valid) begin
                  valid_in[rd_idx_ff] = 1'b0;
                  mask_in[rd_idx_ff]  = 1'b1;
               end
            end
         end
         BK_EVICT: begin
            if (evict_hit) begin
               valid_in[rd_idx_ff] = 1'b0;
               mask_in[rd_idx_ff]  = 1'b1;
               pick_in             = rd_idx_ff;
            end
         end
         BK_SCAN: begin
            if (stop_hit || tick_hit) begin
               valid_in[rd_idx_ff] = 1'b0;
               mask_in[rd_idx_ff]  = 1'b1;
            end
         end
         BK_CLEAR: begin
            mask_in  = valid_ff & nmask;
            valid_in = valid_ff & ~nmask;
         end
         BK_WRITE: begin
            valid_in[pick_ff] = 1'b1;
            status_in         = ST_GRANTED;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         addr_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         kill_done_ff  <= 1'b0;
         reuse_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         kill_done_ff  <= kill_done_in;
         reuse_done_ff <= reuse_done_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff   <= mask_in;
      pick_ff   <= pick_in;
      status_ff <= status_in;
      rd_idx_ff <= addr_ff[IDX_W-1:0];
      if (q_take && q_valid) begin
         cmd_ff  <= q_cmd;
         emit_ff <= q_emit;
         now_ff  <= q_now;
         end_ff  <= q_end;
      end
   end

   assign rsp_data = '{status: status_ff, channel_index: 4'(pick_ff),
                       freed_mask: 16'(mask_ff)};

   a_grant_marks_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_ff == ST_GRANTED) |-> valid_ff[pick_ff])
      else $error("granted channel is not marked valid");

   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_ff == ST_GRANTED) |-> (CNT_W'(pick_ff) < n_eff))
      else $error("granted channel lies beyond the channel count");

   a_freed_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((mask_ff & ~nmask) == '0))
      else $error("freed a channel beyond the channel count");

   a_no_grant_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_ff != ST_GRANTED) |-> (pick_ff == '0))
      else $error("channel index reported without a grant");

endmodule

`default_nettype wire

### src/priority_voice_channel_allocator_top.sv
`default_nettype none

// Channel   Ports                               Handshake
// request   start, busy, req_data               beat taken when start is high and busy is low
// result    rsp_valid, rsp_data                 one-cycle strobe, always taken
// config    csr_we, csr_index, csr_wdata        write when csr_we is high, no wait
//
// Every request gives exactly one result beat, in order. The back end walks the channel
// table one channel a cycle through a registered-read memory: a start first looks for a free or
// matching channel and, if none turns up, scans again for one to evict; stop and tick scan the
// table once, stop all clears it without a scan, and a disabled request needs no scan.
// A two-beat command queue decouples intake; busy rises only when it holds two beats.
// Reset is synchronous and clears the channel valid bits at once; no clearing pass is needed.

module priority_voice_channel_allocator_top #(
   parameter int NUM_CHANNELS = 16,
   parameter int EMITTER_BITS = 16,
   parameter int TIME_BITS    = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire pvca_pkg::pvca_req_type              req_data,
   output logic                                     rsp_valid,
   output pvca_pkg::pvca_rsp_type                   rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [pvca_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pvca_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pvca_pkg::*;

   pvca_cfg_type            cfg_ff, cfg_in;
   logic                    q_valid;
   logic                    q_take;
   pvca_cmd_type            q_cmd;
   logic [EMITTER_BITS-1:0] q_emit;
   logic [TIME_BITS-1:0]    q_now;
   logic [TIME_BITS-1:0]    q_end;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHANNELS: cfg_in.channels_in_use = csr_wdata;
            CSR_ENABLE:   cfg_in.sound_enabled   = csr_wdata[0];
            CSR_COMPAT:   cfg_in.compat_kill_any = csr_wdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{channels_in_use: CHANNELS_RESET, sound_enabled: 1'b1,
                     compat_kill_any: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pvca_front #(
      .EMITTER_BITS (EMITTER_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (cfg_ff.sound_enabled),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_emit   (q_emit),
      .q_now    (q_now),
      .q_end    (q_end),
      .q_take   (q_take)
   );

   pvca_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .EMITTER_BITS (EMITTER_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_emit    (q_emit),
      .q_now     (q_now),
      .q_end     (q_end),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import pvca_pkg::*;

   localparam int NUM_CH = 16;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   pvca_req_type req_data = '0;
   logic         rsp_valid;
   pvca_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   priority_voice_channel_allocator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the channel table and of the control registers.
   logic        ch_live   [NUM_CH];
   logic [15:0] ch_source [NUM_CH];
   logic        ch_pickup [NUM_CH];
   logic [7:0]  ch_prio   [NUM_CH];
   logic [31:0] ch_end    [NUM_CH];
   logic [4:0]  cfg_count    = CHANNELS_RESET;
   logic        cfg_enable   = 1'b1;
   logic        cfg_kill_any = 1'b0;

   pvca_rsp_type outcome_q[$];
   pvca_rsp_type want;
   int          err_count  = 0;
   int          burst_left = 0;
   logic        idle_on    = 1'b1;
   logic [31:0] now_track  = '0;

   initial begin
      for (int i = 0; i < NUM_CH; i++) begin
         ch_live[i]   = 1'b0;
         ch_source[i] = '0;
         ch_pickup[i] = 1'b0;
         ch_prio[i]   = '0;
         ch_end[i]    = '0;
      end
   end

   function automatic pvca_rsp_type allocate_channels(pvca_req_type r);
      pvca_rsp_type o;
      int          n;
      int          slot;
      logic        stopped;
      logic [15:0] freed;
      n = (cfg_count > NUM_CH) ? NUM_CH : int'(cfg_count);
      freed = '0;
      o.status = ST_DONE;
      o.channel_index = '0;
      if (r.req_type == REQ_START) begin
         o.status = ST_REJECTED;
         if (cfg_enable) begin
            // An older sound of the same emitter is cut first.
            slot = -1;
            for (int i = 0; i < n; i++) begin
               if (slot < 0 && ch_live[i] && ch_source[i] == r.emitter_id &&
                   (cfg_kill_any || ch_pickup[i] == r.pickup))
                  slot = i;
            end
            if (slot >= 0) begin
               ch_live[slot] = 1'b0;
               freed[slot] = 1'b1;
            end
            // First free channel, or first live one that the same source can reuse.
            slot = -1;
            for (int i = 0; i < n; i++) begin
               if (slot < 0 && (!ch_live[i] || (r.emitter_id != 0 &&
                   ch_source[i] == r.emitter_id && ch_pickup[i] == r.pickup)))
                  slot = i;
            end
            if (slot >= 0 && ch_live[slot])
               freed[slot] = 1'b1;
            if (slot < 0) begin
               for (int i = 0; i < n; i++) begin
                  if (slot < 0 && ch_live[i] && ch_prio[i] >= r.sound_priority)
                     slot = i;
               end
               if (slot >= 0)
                  freed[slot] = 1'b1;
            end
            if (slot >= 0) begin
               ch_live[slot]   = 1'b1;
               ch_source[slot] = r.emitter_id;
               ch_pickup[slot] = r.pickup;
               ch_prio[slot]   = r.sound_priority;
               ch_end[slot]    = r.now_time + {8'd0, r.play_length};
               o.status        = ST_GRANTED;
               o.channel_index = slot[3:0];
            end
         end
      end else if (cfg_enable) begin
         stopped = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (ch_live[i]) begin
               case (r.req_type)
                  REQ_STOP: begin
                     if (!stopped && ch_source[i] == r.emitter_id) begin
                        ch_live[i] = 1'b0;
                        freed[i] = 1'b1;
                        stopped = 1'b1;
                     end
                  end
                  REQ_STOP_ALL: begin
                     ch_live[i] = 1'b0;
                     freed[i] = 1'b1;
                  end
                  default: begin
                     if (r.now_time >= ch_end[i]) begin
                        ch_live[i] = 1'b0;
                        freed[i] = 1'b1;
                     end
                  end
               endcase
            end
         end
      end
      o.freed_mask = freed;
      return o;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      err_count++;
   endtask

   // Every result beat is checked against the oldest outstanding outcome.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (outcome_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result beat %h", rsp_data));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch($sformatf("status %0d, expected %0d",
                  rsp_data.status, want.status));
            if (rsp_data.channel_index !== want.channel_index)
               flag_mismatch($sformatf("channel_index %0d, expected %0d",
                  rsp_data.channel_index, want.channel_index));
            if (rsp_data.freed_mask !== want.freed_mask)
               flag_mismatch($sformatf("freed_mask %h, expected %h",
                  rsp_data.freed_mask, want.freed_mask));
         end
      end
   end

   task automatic send_req(input pvca_req_type item);
      int gap;
      if (burst_left == 0) begin
         if (idle_on) begin
            gap = $urandom_range(1, 30);
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      start = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy !== 1'b0);
      outcome_q.push_back(allocate_channels(item));
      burst_left--;
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [15:0] emitter,
                              input logic [7:0] prio, input logic pick,
                              input logic [23:0] len, input logic [31:0] now);
      pvca_req_type item;
      item.req_type       = kind;
      item.emitter_id     = emitter;
      item.sound_priority = prio;
      item.pickup         = pick;
      item.play_length    = len;
      item.now_time       = now;
      send_req(item);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      burst_left = 0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = data;
      case (index)
         CSR_CHANNELS: cfg_count = data;
         CSR_ENABLE:   cfg_enable = data[0];
         CSR_COMPAT:   cfg_kill_any = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic pvca_req_type make_random_item();
      pvca_req_type item;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         item.req_type = REQ_START;
      else if (roll < 70)
         item.req_type = REQ_STOP;
      else if (roll < 75)
         item.req_type = REQ_STOP_ALL;
      else
         item.req_type = REQ_TICK;
      // A small pool of sources makes kills, reuse and stops likely.
      roll = $urandom_range(0, 99);
      if (roll < 85)
         item.emitter_id = 16'($urandom_range(0, 5));
      else if (roll < 90)
         item.emitter_id = 16'hFFFF;
      else
         item.emitter_id = 16'($urandom);
      roll = $urandom_range(0, 9);
      if (roll < 7)
         item.sound_priority = 8'($urandom_range(0, 255));
      else if (roll < 8)
         item.sound_priority = 8'd0;
      else if (roll < 9)
         item.sound_priority = 8'd255;
      else
         item.sound_priority = 8'd128;
      item.pickup = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85)
         item.play_length = 24'($urandom_range(0, 2000));
      else
         item.play_length = 24'($urandom);
      if ($urandom_range(0, 99) < 2)
         now_track = $urandom;
      else
         now_track = now_track + 32'($urandom_range(0, 400));
      item.now_time = now_track;
      return item;
   endfunction

   task automatic test_basic_alloc();
      write_csr(CSR_CHANNELS, 5'd4);
      send_fields(REQ_START, 16'd1, 8'd100, 1'b0, 24'd100, 32'd0);
      send_fields(REQ_START, 16'd2, 8'd50,  1'b0, 24'd100, 32'd10);
      // Same emitter with the other pickup flag is not killed in normal mode.
      send_fields(REQ_START, 16'd1, 8'd10,  1'b1, 24'd300, 32'd20);
      send_fields(REQ_START, 16'd1, 8'd100, 1'b0, 24'd100, 32'd30);
      send_fields(REQ_START, 16'd3, 8'd200, 1'b0, 24'd100, 32'd40);
      // Table is full: the first channel of at least equal priority is evicted.
      send_fields(REQ_START, 16'd4, 8'd60,  1'b0, 24'd5000, 32'd50);
      send_fields(REQ_START, 16'd5, 8'd255, 1'b1, 24'd100, 32'd60);
      send_fields(REQ_START, 16'd0, 8'd0,   1'b0, 24'd100, 32'd70);
      send_fields(REQ_STOP,  16'd2, 8'd0,   1'b0, 24'd0,   32'd80);
      send_fields(REQ_TICK,  16'd0, 8'd0,   1'b0, 24'd0,   32'd1000);
      send_fields(REQ_STOP_ALL, 16'd0, 8'd0, 1'b0, 24'd0,  32'd1100);
   endtask

   task automatic test_extremes();
      write_csr(CSR_CHANNELS, 5'd16);
      send_fields(REQ_START, 16'hFFFF, 8'hFF, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF);
      send_fields(REQ_START, 16'h0000, 8'h00, 1'b0, 24'h000000, 32'h00000000);
      send_fields(REQ_TICK,  16'h0000, 8'h00, 1'b0, 24'h000000, 32'h00000000);
      send_fields(REQ_TICK,  16'hFFFF, 8'hFF, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF);
   endtask

   task automatic test_config_modes();
      write_csr(CSR_COMPAT, 5'd1);
      send_fields(REQ_START, 16'd7, 8'd20, 1'b0, 24'd500, 32'd0);
      send_fields(REQ_START, 16'd7, 8'd20, 1'b1, 24'd500, 32'd0);
      write_csr(CSR_COMPAT, 5'd0);
      // With no channels in use every start is turned away.
      write_csr(CSR_CHANNELS, 5'd0);
      send_fields(REQ_START, 16'd8, 8'd20, 1'b0, 24'd500, 32'd0);
      send_fields(REQ_TICK,  16'd0, 8'd0,  1'b0, 24'd0,   32'hFFFFFFFF);
      write_csr(CSR_CHANNELS, 5'd31);
      send_fields(REQ_START, 16'd9, 8'd20, 1'b0, 24'd500, 32'd0);
      send_fields(REQ_START, 16'd9, 8'd20, 1'b0, 24'd500, 32'd0);
      // Only bit zero of the enable write counts.
      write_csr(CSR_ENABLE, 5'b11110);
      send_fields(REQ_START,    16'd10, 8'd20, 1'b0, 24'd500, 32'd0);
      send_fields(REQ_STOP,     16'd9,  8'd0,  1'b0, 24'd0,   32'd0);
      send_fields(REQ_STOP_ALL, 16'd0,  8'd0,  1'b0, 24'd0,   32'd0);
      write_csr(CSR_ENABLE, 5'b00001);
   endtask

   task automatic test_random_traffic();
      logic [4:0] counts[6];
      counts = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd8, 5'd0};
      counts[5] = 5'($urandom_range(0, 31));
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_CHANNELS, counts[phase]);
         write_csr(CSR_COMPAT, 5'($urandom));
         write_csr(CSR_ENABLE, ($urandom_range(0, 7) == 0) ? 5'd0 : 5'd1);
         idle_on = (phase != 2);
         for (int k = 0; k < 85; k++)
            send_req(make_random_item());
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_basic_alloc();
      test_extremes();
      test_config_modes();
      test_random_traffic();
      @(negedge clock);
      start = 1'b0;
      for (int c = 0; c < 5000 && outcome_q.size() != 0; c++)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (outcome_q.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
